/* design/mtm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtm_pkg
// Shared types, constants and mapping functions of the MUS to MIDI translator.
// ----------------------------------------------------------------------------
package mtm_pkg;

  // Width of the delay field carried by every result item.
  localparam int DELTA_W = 28;

  // Depth of the queue between front and back.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Velocity given to every channel after reset or restart.
  localparam logic [7:0] VEL_INIT = 8'd100;

  // MIDI status nibbles.
  localparam logic [3:0] ST_NOTE_ON = 4'h9;
  localparam logic [3:0] ST_CTRL    = 4'hB;
  localparam logic [3:0] ST_PROGRAM = 4'hC;
  localparam logic [3:0] ST_BEND    = 4'hE;

  // MUS event types.
  localparam logic [2:0] MUS_NOTE_OFF = 3'd0;
  localparam logic [2:0] MUS_NOTE_ON  = 3'd1;
  localparam logic [2:0] MUS_BEND     = 3'd2;
  localparam logic [2:0] MUS_SYSTEM   = 3'd3;

  // First MUS event type that ends the score (score end and the undefined types).
  localparam logic [2:0] MUS_END_FIRST = 3'd5;

  // MUS and MIDI controller numbers with special handling, and the data maximum.
  localparam logic [7:0] MUS_CTL_MONO = 8'd12;
  localparam logic [7:0] MIDI_CTL_VOL = 8'd7;
  localparam logic [7:0] DATA_MAX     = 8'h7F;

  // What the back part does with a queued operation.
  typedef enum logic [1:0] {
    K_EMIT      = 2'd0,
    K_VEL_READ  = 2'd1,
    K_VEL_WRITE = 2'd2,
    K_RESTART   = 2'd3
  } mtm_kind_t;

  // One operation handed from front to back.
  typedef struct packed {
    mtm_kind_t          kind;
    logic [DELTA_W-1:0] delta;
    logic [7:0]         status;
    logic [7:0]         data_one;
    logic [7:0]         data_two;
    logic               is_nop;
    logic               score_end;
  } mtm_op_t;

  // MUS channel to MIDI channel: 15 goes to the percussion channel 9,
  // channels 9 to 14 move up by one.
  function automatic logic [3:0] midi_channel(input logic [3:0] c);
    logic [3:0] r;
    if (c == 4'd15) begin
      r = 4'd9;
    end else if (c inside {[4'd9:4'd14]}) begin
      r = c + 4'd1;
    end else begin
      r = c;
    end
    return r;
  endfunction

  // MUS controller index to MIDI controller number; unknown indexes give 0.
  function automatic logic [7:0] map_ctl(input logic [7:0] idx);
    logic [7:0] r;
    case (idx)
      8'd0:    r = 8'd0;
      8'd1:    r = 8'd0;
      8'd2:    r = 8'd1;
      8'd3:    r = 8'd7;
      8'd4:    r = 8'd10;
      8'd5:    r = 8'd11;
      8'd6:    r = 8'd91;
      8'd7:    r = 8'd93;
      8'd8:    r = 8'd64;
      8'd9:    r = 8'd67;
      8'd10:   r = 8'd120;
      8'd11:   r = 8'd123;
      8'd12:   r = 8'd126;
      8'd13:   r = 8'd127;
      8'd14:   r = 8'd121;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

/* design/mtm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtm_front
// Byte parser: accepts score bytes, tracks the event phase and the pending
// delay, and turns each completed MUS event or restart into one queued operation.
// ----------------------------------------------------------------------------
module mtm_front import mtm_pkg::*; #(
  parameter int DELAY_BITS = 28
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // score_byte
  input  logic       in_tuser,   // cmd (1 = restart)
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  input  logic       q_full,
  output logic       q_push,
  output mtm_op_t    q_data
);

  typedef enum logic [3:0] {
    PH_EVENT = 4'b0001,
    PH_ARG1  = 4'b0010,
    PH_ARG2  = 4'b0100,
    PH_DELAY = 4'b1000
  } mtm_phase_t;

  mtm_phase_t            phase_r, phase_nxt;
  logic [7:0]            ev_r, ev_nxt;
  logic [7:0]            arg_r, arg_nxt;
  logic [DELAY_BITS-1:0] pend_r, pend_nxt;
  logic                  ended_r, ended_nxt;
  logic [3:0]            nchan_r;

  logic                  accept;
  logic                  emit;
  logic [2:0]            ev_type;
  logic [3:0]            ch;
  logic [7:0]            ctl;
  logic [31:0]           pend_wide;
  logic [DELTA_W-1:0]    delta_now;
  logic                  pend_ovf;
  logic [DELAY_BITS-1:0] pend_shift;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign ev_type   = ev_r[6:4];
  assign ch        = midi_channel(ev_r[3:0]);

  // Delay as carried in a result item.
  assign pend_wide = 32'(pend_r);
  assign delta_now = pend_wide[DELTA_W-1:0];

  // One seven-bit group of the variable-length delay, saturating.
  assign pend_ovf   = |pend_r[DELAY_BITS-1 -: 7];
  assign pend_shift = {pend_r[DELAY_BITS-8:0], in_tdata[6:0]};

  // Channel count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nchan_r <= 4'd0;
    end else if (cfg_wr_en) begin
      nchan_r <= cfg_wr_data;
    end
  end

  // Parser step for one accepted item.
  always_comb begin
    phase_nxt = phase_r;
    ev_nxt    = ev_r;
    arg_nxt   = arg_r;
    pend_nxt  = pend_r;
    ended_nxt = ended_r;
    emit      = 1'b0;
    q_push    = 1'b0;
    ctl       = map_ctl(arg_r);
    q_data    = '{kind: K_EMIT, delta: delta_now, status: 8'd0, data_one: 8'd0,
                  data_two: 8'd0, is_nop: 1'b0, score_end: 1'b0};
    if (accept) begin
      if (in_tuser) begin
        phase_nxt    = PH_EVENT;
        ev_nxt       = 8'd0;
        arg_nxt      = 8'd0;
        pend_nxt     = '0;
        ended_nxt    = 1'b0;
        q_push       = 1'b1;
        q_data.kind  = K_RESTART;
      end else if (!ended_r) begin
        case (phase_r)
          PH_ARG1: begin
            case (ev_type)
              MUS_NOTE_OFF: begin
                emit          = 1'b1;
                q_data.status = {ST_NOTE_ON, ch};
                q_data.data_one = {1'b0, in_tdata[6:0]};
              end
              MUS_NOTE_ON: begin
                if (in_tdata[7]) begin
                  arg_nxt   = in_tdata;
                  phase_nxt = PH_ARG2;
                end else begin
                  emit            = 1'b1;
                  q_data.kind     = K_VEL_READ;
                  q_data.status   = {ST_NOTE_ON, ch};
                  q_data.data_one = in_tdata;
                end
              end
              MUS_BEND: begin
                emit            = 1'b1;
                q_data.status   = {ST_BEND, ch};
                q_data.data_one = {1'b0, in_tdata[0], 6'd0};
                q_data.data_two = {1'b0, in_tdata[7:1]};
              end
              MUS_SYSTEM: begin
                emit            = 1'b1;
                q_data.status   = {ST_CTRL, ch};
                q_data.data_one = map_ctl(in_tdata);
                q_data.data_two = (in_tdata == MUS_CTL_MONO) ? {4'd0, nchan_r} : 8'd0;
              end
              default: begin
                arg_nxt   = in_tdata;
                phase_nxt = PH_ARG2;
              end
            endcase
          end
          PH_ARG2: begin
            emit = 1'b1;
            if (ev_type == MUS_NOTE_ON) begin
              q_data.kind     = K_VEL_WRITE;
              q_data.status   = {ST_NOTE_ON, ch};
              q_data.data_one = {1'b0, arg_r[6:0]};
              q_data.data_two = in_tdata;
            end else if (arg_r == 8'd0) begin
              q_data.status   = {ST_PROGRAM, ch};
              q_data.data_one = in_tdata;
            end else begin
              q_data.status   = {ST_CTRL, ch};
              q_data.data_one = ctl;
              q_data.data_two = (ctl == MIDI_CTL_VOL && in_tdata > DATA_MAX) ?
                                DATA_MAX : in_tdata;
            end
          end
          PH_DELAY: begin
            pend_nxt = pend_ovf ? {DELAY_BITS{1'b1}} : pend_shift;
            if (!in_tdata[7]) begin
              phase_nxt = PH_EVENT;
            end
          end
          default: begin
            // Types 5 to 7 end the score at the event byte.
            if (in_tdata[6:4] >= MUS_END_FIRST) begin
              q_push           = 1'b1;
              q_data.is_nop    = (pend_r != '0);
              q_data.score_end = 1'b1;
              pend_nxt         = '0;
              ended_nxt        = 1'b1;
              phase_nxt        = PH_EVENT;
            end else begin
              ev_nxt    = in_tdata;
              phase_nxt = PH_ARG1;
            end
          end
        endcase
        // A completed event clears the delay; a set last-bit means a delay follows.
        if (emit) begin
          q_push    = 1'b1;
          pend_nxt  = '0;
          phase_nxt = ev_r[7] ? PH_DELAY : PH_EVENT;
        end
      end
    end
  end

  // Parser registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_EVENT;
      ev_r    <= 8'd0;
      arg_r   <= 8'd0;
      pend_r  <= '0;
      ended_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      ev_r    <= ev_nxt;
      arg_r   <= arg_nxt;
      pend_r  <= pend_nxt;
      ended_r <= ended_nxt;
    end
  end

endmodule

/* design/mtm_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtm_fifo
// Short register queue that decouples the parser from the event writer.
// ----------------------------------------------------------------------------
module mtm_fifo import mtm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  mtm_op_t push_data,
  input  logic    pop,
  output mtm_op_t head,
  output logic    full,
  output logic    empty
);

  mtm_op_t            mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage; no reset needed for payload.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop) else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH)) else $error("queue count out of range");
`endif

endmodule

/* design/mtm_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtm_back
// Event writer: applies the per-channel velocity table to queued operations
// and holds the finished result item in the output register.
// ----------------------------------------------------------------------------
module mtm_back import mtm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_empty,
  input  mtm_op_t q_head,
  output logic    q_pop,
  output logic    out_valid,
  input  logic    out_ready,
  output mtm_op_t out_item
);

  logic [7:0] vel_r [16];
  logic       out_valid_r, out_valid_nxt;
  mtm_op_t    out_item_r, out_item_nxt;
  logic [3:0] vch;

  assign vch       = q_head.status[3:0];
  assign q_pop     = !q_empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Result selection for the operation at the queue head.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    if (q_pop && q_head.kind != K_RESTART) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = q_head;
      if (q_head.kind == K_VEL_READ) begin
        out_item_nxt.data_two = vel_r[vch];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  // Velocity table: restart refills it, a note on with velocity writes one entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        vel_r[i] <= VEL_INIT;
      end
    end else if (q_pop && q_head.kind == K_RESTART) begin
      for (int i = 0; i < 16; i++) begin
        vel_r[i] <= VEL_INIT;
      end
    end else if (q_pop && q_head.kind == K_VEL_WRITE) begin
      vel_r[vch] <= q_head.data_two;
    end
  end

`ifndef NO_ASSERTIONS
  a_restart_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_head.kind == K_RESTART) |=> (vel_r[0] == VEL_INIT && vel_r[15] == VEL_INIT))
    else $error("velocity table not refilled on restart");
  a_vel_store: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_head.kind == K_VEL_WRITE) |=> (vel_r[$past(vch)] == $past(q_head.data_two)))
    else $error("velocity not stored");
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_head.kind != K_RESTART) |=> out_valid_r)
    else $error("popped operation gave no result item");
`endif

endmodule

/* design/mus_to_midi_event_translator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mus_to_midi_event_translator_top
// Translates a MUS score, one byte per item, into MIDI short events.
//
//   Channel  Dir  Signals                    Content
//   in_      in   tvalid/tready/tdata/tuser  tdata: score_byte; tuser: cmd
//   out_     out  tvalid/tready/tdata/tuser  tdata: delta_ticks, status_byte,
//                 tlast                      data_one, data_two; tuser: is_nop;
//                                            tlast: score_end
//   cfg_     in   wr_en/wr_data              num_channels
//
// One score byte is accepted every cycle while the four-entry operation
// queue has room. A result item appears on out_ once the byte completing the
// event has passed through a queue entry and then the output register.
// When out_tready is low the queue absorbs up to four more operations before
// in_tready drops. Reset is synchronous.
// ----------------------------------------------------------------------------
module mus_to_midi_event_translator_top import mtm_pkg::*; #(
  parameter int DELAY_BITS = 28
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] score_byte
  input  logic        in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [27:0] delta_ticks, [35:28] status_byte,
                                  // [43:36] data_one, [51:44] data_two, zeros
  output logic        out_tuser,  // [0] is_nop
  output logic        out_tlast,  // score_end
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data
);

  mtm_op_t push_data;
  mtm_op_t head;
  mtm_op_t res;
  logic    push;
  logic    pop;
  logic    full;
  logic    empty;

  // Parser front.
  mtm_front #(
    .DELAY_BITS(DELAY_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .q_full     (full),
    .q_push     (push),
    .q_data     (push_data)
  );

  // Operation queue.
  mtm_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  // Event writer back.
  mtm_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (empty),
    .q_head   (head),
    .q_pop    (pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_item (res)
  );

  // Result packing.
  assign out_tdata = {4'd0, res.data_two, res.data_one, res.status, res.delta};
  assign out_tuser = res.is_nop;
  assign out_tlast = res.score_end;

endmodule
